### rtl/dmwc_pkg.sv
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared types and constants for the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
`default_nettype none
package dmwc_pkg;
  localparam int unsigned AddrW  = 20;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CostW  = 16;
  localparam int unsigned ACostW = 18;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MEM_READ   = 2'd0,
    REG_MEM_WRITE  = 2'd1,
    REG_LINE_READ  = 2'd2,
    REG_LINE_WRITE = 2'd3
  } cfg_reg_t;

  localparam logic [CostW-1:0] MemReadCostRst   = 16'd100;
  localparam logic [CostW-1:0] MemWriteCostRst  = 16'd100;
  localparam logic [CostW-1:0] LineReadCostRst  = 16'd1;
  localparam logic [CostW-1:0] LineWriteCostRst = 16'd1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_EVICT,
    BK_FILL,
    BK_ACCESS,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic             hit;
    logic             evict;
    logic [AddrW-1:0] victim;
  } job_t;
endpackage
`default_nettype wire

### rtl/dmwc_if.sv
// ----------------------------------------------------------------------------
// dmwc_req_if / dmwc_rsp_if / dmwc_cfg_if
// Valid/ready channels of the cache.
// ----------------------------------------------------------------------------
`default_nettype none
interface dmwc_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [19:0] address;
  logic [31:0] write_data;
  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface dmwc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        hit;
  logic [17:0] access_cost;
  logic [31:0] total_time;
  modport source (output valid, read_data, hit, access_cost, total_time, input ready);
  modport sink   (input valid, read_data, hit, access_cost, total_time, output ready);
endinterface

interface dmwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/dmwc_ram.sv
// ----------------------------------------------------------------------------
// dmwc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module dmwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/dmwc_front.sv
// ----------------------------------------------------------------------------
// dmwc_front
// Accepts requests, checks the tag array and queues classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module dmwc_front #(
  parameter int unsigned LINES = 256,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned MEMORY_BYTES = 1048576
) (
  input  wire logic clk,
  input  wire logic rst,
  dmwc_req_if.sink  req,
  input  wire logic en,
  output dmwc_pkg::job_t job,
  output logic      job_valid,
  input  wire logic job_pop,
  output logic      busy
);
  import dmwc_pkg::*;
  localparam int unsigned OffW = $clog2(BLOCK_BYTES);
  localparam int unsigned IdxW = $clog2(LINES);
  localparam int unsigned MemAW = $clog2(MEMORY_BYTES);
  localparam int unsigned TagW = (MemAW > OffW + IdxW) ? MemAW - OffW - IdxW : 1;

  logic            valid_q [LINES];

  job_t          qbuf [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic [MemAW-1:0] a;
  logic [IdxW-1:0]  idx;
  logic [TagW-1:0]  tag;
  logic          acc;
  job_t          nj;
  logic          look;
  logic             r_action;
  logic [AddrW-1:0] r_address;
  logic [DataW-1:0] r_wdata;
  logic             t_we;
  logic [IdxW-1:0]  t_ad;
  logic [TagW:0]    t_wd, t_rd;

  // tag RAM entry: {dirty, tag}
  dmwc_ram #(.WIDTH(TagW+1), .DEPTH(LINES)) u_tags (
    .clk(clk), .we(t_we), .addr(t_ad), .wdata(t_wd), .rdata(t_rd));

  always_comb begin
    a   = MemAW'(look ? r_address : req.address);
    idx = a[OffW +: IdxW];
    tag = (MemAW > OffW + IdxW) ? TagW'(a >> (OffW + IdxW)) : '0;
    t_ad = idx;
    t_we = look;
    nj.action     = r_action;
    nj.address    = r_address;
    nj.write_data = r_wdata;
    nj.hit        = valid_q[idx] && t_rd[TagW-1:0] == tag;
    nj.evict      = !nj.hit && valid_q[idx] && t_rd[TagW];
    nj.victim     = AddrW'({t_rd[TagW-1:0], idx, {OffW{1'b0}}});
    t_wd = {r_action | (nj.hit & t_rd[TagW]), tag};
  end

  // one queued job at a time so tag state is current when classifying
  assign req.ready = en && cnt == 2'd0 && !look;
  assign acc       = req.valid && req.ready;
  assign job       = qbuf[rp];
  assign job_valid = cnt != 2'd0;
  assign busy      = cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0; look <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      if (acc) begin
        look      <= 1'b1;
        r_action  <= req.action;
        r_address <= req.address;
        r_wdata   <= req.write_data;
      end
      if (look) begin
        look <= 1'b0;
        qbuf[wp] <= nj;
        wp <= ~wp;
        valid_q[idx] <= 1'b1;
      end
      if (job_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, look} - {1'b0, job_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) job_pop |-> job_valid)
    else $error("pop of empty queue");
  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd1)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) acc |=> look)
    else $error("accepted item not looked up");
  assert property (@(posedge clk) disable iff (rst) look |=> job_valid)
    else $error("accepted job not queued");
endmodule
`default_nettype wire

### rtl/dmwc_back.sv
// ----------------------------------------------------------------------------
// dmwc_back
// Executes jobs: write-back, block fill, word access, cost accounting.
// ----------------------------------------------------------------------------
`default_nettype none
module dmwc_back #(
  parameter int unsigned LINES = 256,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned MEMORY_BYTES = 1048576
) (
  input  wire logic clk,
  input  wire logic rst,
  input  dmwc_pkg::job_t job,
  input  wire logic job_valid,
  output logic      job_pop,
  output logic      ready_in,
  dmwc_rsp_if.source rsp,
  dmwc_cfg_if.sink   cfg
);
  import dmwc_pkg::*;
  localparam int unsigned OffW  = $clog2(BLOCK_BYTES);
  localparam int unsigned IdxW  = $clog2(LINES);
  localparam int unsigned MemAW = $clog2(MEMORY_BYTES);
  localparam int unsigned BWords = BLOCK_BYTES / 4;
  localparam int unsigned WW    = $clog2(BWords);
  localparam int unsigned MWords = MEMORY_BYTES / 4;
  localparam int unsigned MWA   = $clog2(MWords);
  localparam int unsigned LWA   = IdxW + WW;

  bk_state_t state, state_next;
  logic [CostW-1:0] mrc, mwc, lrc, lwc;
  logic [MWA-1:0]   ccnt;
  logic [WW:0]      wcnt;
  logic             ph;
  logic [ACostW-1:0] cost;
  logic [DataW-1:0]  total;

  logic [MemAW-1:0] a;
  logic [IdxW-1:0]  idx;
  logic [WW-1:0]    wsel;
  assign a    = MemAW'(job.address);
  assign idx  = a[OffW +: IdxW];
  assign wsel = a[2 +: WW];

  logic             m_we, l_we;
  logic [MWA-1:0]   m_ad;
  logic [LWA-1:0]   l_ad;
  logic [DataW-1:0] m_wd, l_wd, m_rd, l_rd;

  dmwc_ram #(.WIDTH(DataW), .DEPTH(MWords)) u_mem (
    .clk(clk), .we(m_we), .addr(m_ad), .wdata(m_wd), .rdata(m_rd));
  dmwc_ram #(.WIDTH(DataW), .DEPTH(LINES*BWords)) u_line (
    .clk(clk), .we(l_we), .addr(l_ad), .wdata(l_wd), .rdata(l_rd));

  logic [MWA-1:0] old_base, new_base;
  always_comb begin
    old_base = MWA'(job.victim[AddrW-1:2]);
    new_base = MWA'({a[MemAW-1:OffW], {WW{1'b0}}});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (job_valid) state_next = job.hit ? BK_ACCESS :
                                  (job.evict ? BK_EVICT : BK_FILL);
      BK_CLEAR:  if (ccnt == MWA'(MWords - 1)) state_next = BK_IDLE;
      BK_EVICT:  if (wcnt == (WW+1)'(BWords - 1) && ph) state_next = BK_FILL;
      BK_FILL:   if (wcnt == (WW+1)'(BWords - 1) && ph) state_next = BK_ACCESS;
      BK_ACCESS: if (ph) state_next = BK_DONE;
      BK_DONE:   if (rsp.ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // per copied word (evict, fill): source address on the first phase, write on the second
  always_comb begin
    m_we = 1'b0; l_we = 1'b0;
    m_ad = '0; l_ad = '0; m_wd = l_rd; l_wd = m_rd;
    unique case (state)
      BK_CLEAR: begin m_we = 1'b1; m_ad = ccnt; m_wd = '0; end
      BK_EVICT: begin
        if (!ph) l_ad = {idx, wcnt[WW-1:0]};
        else begin
          m_we = 1'b1;
          m_ad = old_base + MWA'(wcnt);
        end
      end
      BK_FILL: begin
        if (!ph) m_ad = new_base + MWA'(wcnt);
        else begin
          l_we = 1'b1;
          l_ad = {idx, wcnt[WW-1:0]};
        end
      end
      BK_ACCESS: begin
        l_ad = {idx, wsel};
        l_we = job.action && !ph;
        l_wd = job.write_data;
      end
      default: ;
    endcase
  end

  assign job_pop  = state == BK_DONE && rsp.ready;
  assign ready_in = state != BK_CLEAR;
  assign rsp.valid = state == BK_DONE;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR; ccnt <= '0; wcnt <= '0; ph <= 1'b0; total <= '0;
      mrc <= MemReadCostRst; mwc <= MemWriteCostRst;
      lrc <= LineReadCostRst; lwc <= LineWriteCostRst;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_MEM_READ:   mrc <= cfg.data;
          REG_MEM_WRITE:  mwc <= cfg.data;
          REG_LINE_READ:  lrc <= cfg.data;
          REG_LINE_WRITE: lwc <= cfg.data;
          default: ;
        endcase
      end
      if (state == BK_CLEAR) ccnt <= ccnt + 1'b1;
      if (state == BK_EVICT || state == BK_FILL) begin
        ph <= ~ph;
        if (ph) wcnt <= (state_next != state) ? '0 : wcnt + 1'b1;
      end else if (state == BK_ACCESS) ph <= ~ph;
      else begin ph <= 1'b0; wcnt <= '0; end
      if (state == BK_ACCESS && ph) total <= total + DataW'(cost);
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && job_valid)
      cost <= ACostW'(job.hit ? 0 : mrc) + ACostW'(job.evict ? mwc : 0)
            + ACostW'(job.action ? lwc : lrc);
    if (state == BK_ACCESS && ph) begin
      rsp.read_data <= job.action ? '0 : l_rd;
      rsp.hit       <= job.hit;
    end
  end
  assign rsp.access_cost = cost;
  assign rsp.total_time  = total;

  assert property (@(posedge clk) disable iff (rst) rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("response dropped");
  assert property (@(posedge clk) disable iff (rst) job_pop |-> job_valid)
    else $error("pop without job");
  assert property (@(posedge clk) disable iff (rst) (m_we && l_we) == 1'b0)
    else $error("both stores written");
endmodule
`default_nettype wire

### rtl/direct_mapped_writeback_cache_unit.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_unit
// Direct-mapped write-allocate write-back cache over a word memory.
//
//   channel  dir  payload
//   req      in   action, address, write_data
//   rsp      out  read_data, hit, access_cost, total_time
//   cfg      in   index, data (cost registers)
//
// Hit: tag lookup, dispatch, two-phase word access and response per item.
// Miss: a block fill is added, and before it a write-back for a dirty
// victim; each word takes an address and a data phase on single-port RAMs.
// After reset the backing memory is cleared; no req is accepted until then.
// A stalled response holds the back end; the front holds one queued item.
// ----------------------------------------------------------------------------
`default_nettype none
module direct_mapped_writeback_cache_unit #(
  parameter int unsigned LINES = 256,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned MEMORY_BYTES = 1048576
) (
  input wire logic clk,
  input wire logic rst,
  dmwc_req_if.sink   req,
  dmwc_rsp_if.source rsp,
  dmwc_cfg_if.sink   cfg
);
  import dmwc_pkg::*;
  job_t job;
  logic job_valid, job_pop, en, busy;

  dmwc_front #(.LINES(LINES), .BLOCK_BYTES(BLOCK_BYTES), .MEMORY_BYTES(MEMORY_BYTES))
    u_front (.clk(clk), .rst(rst), .req(req), .en(en), .job(job),
             .job_valid(job_valid), .job_pop(job_pop), .busy(busy));
  dmwc_back #(.LINES(LINES), .BLOCK_BYTES(BLOCK_BYTES), .MEMORY_BYTES(MEMORY_BYTES))
    u_back (.clk(clk), .rst(rst), .job(job), .job_valid(job_valid),
            .job_pop(job_pop), .ready_in(en), .rsp(rsp), .cfg(cfg));

  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> busy)
    else $error("response without job");
  assert property (@(posedge clk) disable iff (rst) req.ready |-> !busy)
    else $error("accepting while busy");
  assert property (@(posedge clk) disable iff (rst) !en |-> !req.ready)
    else $error("accept during clear");
endmodule
`default_nettype wire

### sim/tb_direct_mapped_writeback_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_direct_mapped_writeback_cache_unit
// Self-checking bench for the direct-mapped write-back cache. A behavioral
// cache model predicts hit, read data, access cost and running time for every
// accepted request. Directed hit, miss and dirty-eviction cases come first,
// then random traffic over a few conflicting lines under several cost
// settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_direct_mapped_writeback_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dmwc_pkg::*;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct {
    logic        action;
    logic [19:0] address;
    logic [31:0] write_data;
  } access_t;

  typedef struct {
    logic [31:0] read_data;
    logic        hit;
    logic [17:0] access_cost;
    logic [31:0] total_time;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dmwc_req_if req_ch ();
  dmwc_rsp_if rsp_ch ();
  dmwc_cfg_if cfg_ch ();

  direct_mapped_writeback_cache_unit dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  always #1 clk = ~clk;

  // cache model state
  logic        m_valid [256];
  logic        m_dirty [256];
  logic [5:0]  m_tag   [256];
  logic [31:0] m_line  [4096];
  logic [31:0] m_mem   [int];
  logic [31:0] m_elapsed;
  logic [15:0] c_mem_rd, c_mem_wr, c_line_rd, c_line_wr;

  access_t  pending_items[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  bit       idle_en = 1'b1;
  int       req_gap = 0;
  int       rsp_gap = 0;

  function automatic logic [31:0] mem_rd(int a);
    return m_mem.exists(a) ? m_mem[a] : 32'h0;
  endfunction

  function automatic outcome_t cache_access(access_t a);
    outcome_t    o;
    logic [13:0] blk;
    logic [7:0]  idx;
    logic [5:0]  tg;
    logic [3:0]  wd;
    logic [31:0] cost;
    blk = a.address[19:6];
    idx = blk[7:0];
    tg  = blk[13:8];
    wd  = a.address[5:2];
    cost = 0;
    o.read_data = 0;
    o.hit = m_valid[idx] && m_tag[idx] == tg;
    if (!o.hit) begin
      if (m_valid[idx] && m_dirty[idx]) begin
        for (int w = 0; w < 16; w++)
          m_mem[{m_tag[idx], idx, w[3:0]}] = m_line[{idx, w[3:0]}];
        cost += c_mem_wr;
      end
      for (int w = 0; w < 16; w++)
        m_line[{idx, w[3:0]}] = mem_rd({tg, idx, w[3:0]});
      cost += c_mem_rd;
      m_valid[idx] = 1'b1;
      m_tag[idx] = tg;
      m_dirty[idx] = 1'b0;
    end
    if (a.action == ACT_READ) begin
      o.read_data = m_line[{idx, wd}];
      cost += c_line_rd;
    end else begin
      m_line[{idx, wd}] = a.write_data;
      cost += c_line_wr;
      m_dirty[idx] = 1'b1;
    end
    m_elapsed += cost;
    o.access_cost = cost[17:0];
    o.total_time = m_elapsed;
    return o;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        req_gap <= $urandom_range(0, 13);
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        access_t a;
        a = pending_items.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= a.action;
        req_ch.address <= a.address;
        req_ch.write_data <= a.write_data;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_outcomes.push_back(cache_access('{req_ch.action, req_ch.address,
                                                   req_ch.write_data}));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected response item", $time);
        end else begin
          outcome_t e;
          e = expected_outcomes.pop_front();
          if (rsp_ch.read_data !== e.read_data) begin
            errors++;
            $display("%0t: read_data exp %h got %h", $time, e.read_data, rsp_ch.read_data);
          end
          if (rsp_ch.hit !== e.hit) begin
            errors++;
            $display("%0t: hit exp %b got %b", $time, e.hit, rsp_ch.hit);
          end
          if (rsp_ch.access_cost !== e.access_cost) begin
            errors++;
            $display("%0t: access_cost exp %0d got %0d", $time, e.access_cost,
                     rsp_ch.access_cost);
          end
          if (rsp_ch.total_time !== e.total_time) begin
            errors++;
            $display("%0t: total_time exp %0d got %0d", $time, e.total_time,
                     rsp_ch.total_time);
          end
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        rsp_gap <= $urandom_range(0, 13);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (r)
      REG_MEM_READ:  c_mem_rd = v;
      REG_MEM_WRITE: c_mem_wr = v;
      REG_LINE_READ: c_line_rd = v;
      default:       c_line_wr = v;
    endcase
  endtask

  task automatic add_item(logic act, logic [19:0] addr, logic [31:0] d);
    pending_items.push_back('{act, addr, d});
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !req_ch.valid && expected_outcomes.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic add_random(int n);
    logic [5:0]  tg;
    logic [7:0]  idx;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        tg  = 6'($urandom_range(0, 3));
        idx = 8'($urandom_range(0, 7));
        add_item(1'($urandom_range(0, 1)), {tg, idx, 6'($urandom)}, $urandom);
      end else begin
        add_item(1'($urandom_range(0, 1)), 20'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      m_valid[i] = 0;
      m_dirty[i] = 0;
      m_tag[i] = 0;
    end
    for (int i = 0; i < 4096; i++) m_line[i] = 0;
    m_elapsed = 0;
    c_mem_rd = MemReadCostRst;
    c_mem_wr = MemWriteCostRst;
    c_line_rd = LineReadCostRst;
    c_line_wr = LineWriteCostRst;
    req_ch.valid = 0;
    req_ch.action = ACT_READ;
    req_ch.address = 0;
    req_ch.write_data = 0;
    rsp_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_MEM_READ;
    cfg_ch.data = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: cold miss, hit, dirty eviction, refill, ignored low bits, extremes
    add_item(ACT_READ,  20'h00000, 32'h12345678);
    add_item(ACT_WRITE, 20'h00000, 32'hFFFFFFFF);
    add_item(ACT_READ,  20'h00003, 32'h0);
    add_item(ACT_WRITE, 20'h0003E, 32'hA5A5A5A5);
    add_item(ACT_READ,  20'h0003C, 32'h0);
    add_item(ACT_READ,  20'h04000, 32'h0);
    add_item(ACT_READ,  20'h00000, 32'h0);
    add_item(ACT_READ,  20'h0003D, 32'h0);
    add_item(ACT_WRITE, 20'hFFFFF, 32'h00000000);
    add_item(ACT_WRITE, 20'hFFFFC, 32'h5A5A5A5A);
    add_item(ACT_READ,  20'h03FFC, 32'h0);
    add_item(ACT_READ,  20'hFFFFF, 32'h0);
    add_item(ACT_WRITE, 20'h03FC0, 32'h0F0F0F0F);
    add_item(ACT_READ,  20'hFFFC0, 32'h0);
    add_item(ACT_READ,  20'h03FC0, 32'h0);
    add_item(ACT_WRITE, 20'h80040, 32'h80000001);
    add_item(ACT_READ,  20'h00040, 32'h0);
    add_item(ACT_READ,  20'h80040, 32'h0);
    drain();
    add_random(150);
    drain();

    write_reg(REG_MEM_READ, 16'hFFFF);
    write_reg(REG_MEM_WRITE, 16'hFFFF);
    write_reg(REG_LINE_READ, 16'hFFFF);
    write_reg(REG_LINE_WRITE, 16'hFFFF);
    add_random(170);
    drain();

    write_reg(REG_MEM_READ, 16'h0);
    write_reg(REG_MEM_WRITE, 16'h0);
    write_reg(REG_LINE_READ, 16'h0);
    write_reg(REG_LINE_WRITE, 16'h0);
    add_random(170);
    drain();

    write_reg(REG_MEM_READ, 16'($urandom));
    write_reg(REG_MEM_WRITE, 16'($urandom));
    write_reg(REG_LINE_READ, 16'($urandom));
    write_reg(REG_LINE_WRITE, 16'($urandom));
    add_random(100);
    wait (pending_items.size() == 0 && !req_ch.valid);
    idle_en = 1'b0;
    add_random(100);
    wait (pending_items.size() == 0 && !req_ch.valid && expected_outcomes.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
